// ===== hdl/tbd_pkg.sv =====
`timescale 1ns / 1ps

package tbd_pkg;

  localparam int ROUNDS      = 32;
  localparam int HALF_ROUNDS = 2 * ROUNDS;
  localparam int WORD_W      = 32;
  localparam int KEY_COUNT   = 4;
  localparam int CFG_IDX_W   = $clog2(KEY_COUNT);

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E3779B9;

  localparam logic [CFG_IDX_W-1:0] KEY_IDX_0 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] KEY_IDX_3 = CFG_IDX_W'(3);

  localparam logic [WORD_W-1:0] KEY_RESET_0 = 32'h075BCC20;
  localparam logic [WORD_W-1:0] KEY_RESET_1 = 32'h2CFBC8D8;
  localparam logic [WORD_W-1:0] KEY_RESET_2 = 32'h0DF9825C;
  localparam logic [WORD_W-1:0] KEY_RESET_3 = 32'h387BB876;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } key_t;

  // p is the word fed into the mix, q the word it updates.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] q;
  } stage_t;

  function automatic logic [WORD_W-1:0] round_sum(input int r);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(ROUNDS - r);
    return prod[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] w,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] kshl,
                                                input logic [WORD_W-1:0] kshr);
    return ((w << 4) + kshl) ^ (w + sum) ^ ((w >> 5) + kshr);
  endfunction

endpackage

// ===== hdl/tea_block_decrypt_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     in_valid / in_stall     cipher_word_a, cipher_word_b
// output    out_valid / out_stall   plain_word_a, plain_word_b
// config    cfg_write               cfg_index, cfg_data
//
// A block passes from input transfer to output through one half round per cell
// of the chain and then the output register; one block is accepted every cycle
// while in_stall is low.
// Reset clears the valid bits and loads the fixed key.
// An output stall is absorbed by a one-entry skid register, whose fill freezes
// the chain and raises in_stall.

module tea_block_decrypt_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tbd_pkg::WORD_W-1:0]    cipher_word_a,
  input  logic [tbd_pkg::WORD_W-1:0]    cipher_word_b,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tbd_pkg::WORD_W-1:0]    plain_word_a,
  output logic [tbd_pkg::WORD_W-1:0]    plain_word_b,
  input  logic                          cfg_write,
  input  logic [tbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbd_pkg::WORD_W-1:0]    cfg_data
);
  import tbd_pkg::*;

  key_t   key;
  logic   pipe_en;
  stage_t stages [HALF_ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key.k0 <= KEY_RESET_0;
      key.k1 <= KEY_RESET_1;
      key.k2 <= KEY_RESET_2;
      key.k3 <= KEY_RESET_3;
    end else if (cfg_write) begin
      unique case (cfg_index)
        KEY_IDX_0: key.k0 <= cfg_data;
        KEY_IDX_1: key.k1 <= cfg_data;
        KEY_IDX_2: key.k2 <= cfg_data;
        KEY_IDX_3: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = !pipe_en;

  assign stages[0] = '{valid: in_valid, p: cipher_word_a, q: cipher_word_b};

  for (genvar h = 0; h < HALF_ROUNDS; h++) begin : g_cell
    localparam logic [WORD_W-1:0] SUM = round_sum(h / 2);
    tbd_half_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .stage_in  (stages[h]),
      .sum       (SUM),
      .kshl      ((h % 2 == 0) ? key.k2 : key.k0),
      .kshr      ((h % 2 == 0) ? key.k3 : key.k1),
      .stage_out (stages[h+1])
    );
  end

  tbd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .stage_in  (stages[HALF_ROUNDS]),
    .pipe_en   (pipe_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_a    (plain_word_a),
    .word_b    (plain_word_b)
  );

endmodule

// ===== hdl/tbd_half_cell.sv =====
`timescale 1ns / 1ps

module tbd_half_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  tbd_pkg::stage_t        stage_in,
  input  logic [tbd_pkg::WORD_W-1:0] sum,
  input  logic [tbd_pkg::WORD_W-1:0] kshl,
  input  logic [tbd_pkg::WORD_W-1:0] kshr,
  output tbd_pkg::stage_t        stage_out
);
  import tbd_pkg::*;

  // The updated word becomes the mixed word of the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else if (en) begin
      stage_out.valid <= stage_in.valid;
    end
    if (en) begin
      stage_out.p <= stage_in.q - tea_mix(stage_in.p, sum, kshl, kshr);
      stage_out.q <= stage_in.p;
    end
  end

endmodule

// ===== hdl/tbd_out_stage.sv =====
`timescale 1ns / 1ps

module tbd_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  tbd_pkg::stage_t        stage_in,
  output logic                   pipe_en,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [tbd_pkg::WORD_W-1:0] word_a,
  output logic [tbd_pkg::WORD_W-1:0] word_b
);
  import tbd_pkg::*;

  logic              skid_valid;
  logic [WORD_W-1:0] skid_a;
  logic [WORD_W-1:0] skid_b;

  assign pipe_en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (pipe_en && stage_in.valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= stage_in.valid;
    end

    if (out_valid && out_stall) begin
      if (pipe_en && stage_in.valid) begin
        skid_a <= stage_in.p;
        skid_b <= stage_in.q;
      end
    end else if (skid_valid) begin
      word_a <= skid_a;
      word_b <= skid_b;
    end else begin
      word_a <= stage_in.p;
      word_b <= stage_in.q;
    end
  end

endmodule
